// ===== rtl/dpm_pkg.sv =====
// Shared types and constants for the demand-paged memory block.
// No dependencies; used by dpm_lru, the top level and the testbench.
package dpm_pkg;

  // Geometry, fixed by the 7-bit virtual address and the 3-bit frame number
  localparam int FRAME_COUNT    = 8;
  localparam int PAGE_BYTES     = 16;
  localparam int PROC_COUNT     = 4;
  localparam int PAGES_PER_PROC = 8;

  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int OFF_W   = $clog2(PAGE_BYTES);
  localparam int VP_W    = $clog2(PAGES_PER_PROC);
  localparam int PROC_W  = $clog2(PROC_COUNT);
  localparam int PE_W    = PROC_W + VP_W;
  localparam int PA_W    = FRAME_W + OFF_W;
  localparam int BA_W    = PE_W + OFF_W;
  localparam int PROC_BYTES = PAGES_PER_PROC * PAGE_BYTES;
  localparam int PROC_BYTES_W = $clog2(PROC_BYTES);
  localparam int LIMIT_W = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [7:0] SPACE = 8'h20;

  // Request codes
  localparam logic [1:0] REQ_READ    = 2'd0;
  localparam logic [1:0] REQ_WRITE   = 2'd1;
  localparam logic [1:0] REQ_PRELOAD = 2'd2;
  localparam logic [1:0] REQ_RELEASE = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] proc_id;
    logic [6:0] vaddr;
    logic [7:0] wdata;
  } req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [1:0] status;
    logic       page_fault;
    logic       evicted;
    logic [2:0] frame_used;
  } rsp_t;

  // Move-to-front command for the LRU list
  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] frame;
  } lru_touch_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_REL, S_WCHK, S_LOOK, S_WB, S_LD, S_ACC, S_RD, S_DONE
  } state_t;

endpackage

// ===== rtl/dpm_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dpm_lru.sv =====
// LRU order of the physical frames, front is most recent, tail is the victim.
// Depends on dpm_pkg.
module dpm_lru (
  input  logic                        clk,
  input  logic                        rst,
  input  dpm_pkg::lru_touch_t         touch,
  output logic [dpm_pkg::FRAME_W-1:0] tail
);

  logic [dpm_pkg::FRAME_W-1:0] order      [dpm_pkg::FRAME_COUNT];
  logic [dpm_pkg::FRAME_W-1:0] order_next [dpm_pkg::FRAME_COUNT];
  logic [dpm_pkg::FRAME_W-1:0] pos;

  // find the frame's place; absent frames count as the tail
  always_comb begin
    pos = dpm_pkg::FRAME_W'(dpm_pkg::FRAME_COUNT - 1);
    for (int i = dpm_pkg::FRAME_COUNT - 1; i >= 0; i--) begin
      if (order[i] == touch.frame) pos = dpm_pkg::FRAME_W'(i);
    end
  end

  // shift everything ahead of it back by one
  always_comb begin
    order_next[0] = touch.frame;
    for (int i = 1; i < dpm_pkg::FRAME_COUNT; i++) begin
      order_next[i] = (dpm_pkg::FRAME_W'(i) <= pos) ? order[i-1] : order[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dpm_pkg::FRAME_COUNT; i++) order[i] <= dpm_pkg::FRAME_W'(i);
    end else if (touch.en) begin
      order <= order_next;
    end
  end

  assign tail = order[dpm_pkg::FRAME_COUNT-1];

endmodule

// ===== rtl/demand_paged_memory_lru.sv =====
// Demand-paged byte memory with LRU frame replacement, top level; one request at a time.
// Preload and out-of-range requests go straight to the response; a write is refused if its
// backing byte is not a space; a resident access uses the page's frame; a fault adds a
// copy-in, after a write-back when no frame is free. Release blanks the process's backing
// bytes and frames. Reset: synchronous; a clearing pass fills both RAMs with spaces before
// the first request is taken (configuration writes are taken outside reset).
module demand_paged_memory_lru (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dpm_pkg::req_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dpm_pkg::rsp_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpm_pkg::LIMIT_W-1:0]     cfg_data
);

  localparam int CNT_W = dpm_pkg::BA_W;

  dpm_pkg::state_t state, state_next;

  // page limits
  logic [dpm_pkg::LIMIT_W-1:0] page_limit [dpm_pkg::PROC_COUNT];

  // page table and frame table in flip-flops
  logic [dpm_pkg::PROC_COUNT*dpm_pkg::PAGES_PER_PROC-1:0] page_valid;
  logic [dpm_pkg::FRAME_W-1:0] page_frame [dpm_pkg::PROC_COUNT*dpm_pkg::PAGES_PER_PROC];
  logic [dpm_pkg::FRAME_COUNT-1:0] frame_free;
  logic [dpm_pkg::PROC_W-1:0]  frame_owner [dpm_pkg::FRAME_COUNT];
  logic [dpm_pkg::VP_W-1:0]    frame_vpage [dpm_pkg::FRAME_COUNT];

  // current request
  dpm_pkg::req_t               cur;
  logic [dpm_pkg::FRAME_W-1:0] frame;
  logic [dpm_pkg::PE_W-1:0]    victim_pe;
  logic [CNT_W-1:0]            cnt;
  dpm_pkg::rsp_t               rsp;

  // RAM ports
  logic                      pr_we, bs_we;
  logic [dpm_pkg::PA_W-1:0]  pr_waddr, pr_raddr;
  logic [dpm_pkg::BA_W-1:0]  bs_waddr, bs_raddr;
  logic [7:0]                pr_wdata, bs_wdata, pr_rdata, bs_rdata;

  dpm_pkg::lru_touch_t         touch;
  logic [dpm_pkg::FRAME_W-1:0] lru_tail;

  // decoded helpers
  logic [dpm_pkg::PE_W-1:0]    cur_pe;
  logic [dpm_pkg::OFF_W-1:0]   cur_off;
  logic [dpm_pkg::LIMIT_W-1:0] limit_raw, limit;
  logic                        in_range;
  logic                        any_free;
  logic [dpm_pkg::FRAME_W-1:0] low_free;
  logic                        copy_done, rel_done, clr_done;
  logic [dpm_pkg::OFF_W-1:0]   copy_rd_off, copy_wr_off;
  logic [dpm_pkg::FRAME_W-1:0] rel_frame;
  logic                        out_load;

  assign cur_pe  = {cur.proc_id, cur.vaddr[dpm_pkg::VP_W+dpm_pkg::OFF_W-1:dpm_pkg::OFF_W]};
  assign cur_off = cur.vaddr[dpm_pkg::OFF_W-1:0];

  // limit of the incoming request's process, clamped to the page count
  assign limit_raw = page_limit[in_data.proc_id];
  assign limit     = (limit_raw > dpm_pkg::LIMIT_W'(dpm_pkg::PAGES_PER_PROC))
                     ? dpm_pkg::LIMIT_W'(dpm_pkg::PAGES_PER_PROC) : limit_raw;
  assign in_range  = dpm_pkg::LIMIT_W'(in_data.vaddr[6:dpm_pkg::OFF_W]) < limit;

  // lowest free frame
  always_comb begin
    any_free = |frame_free;
    low_free = '0;
    for (int i = dpm_pkg::FRAME_COUNT - 1; i >= 0; i--) begin
      if (frame_free[i]) low_free = dpm_pkg::FRAME_W'(i);
    end
  end

  assign copy_rd_off = cnt[dpm_pkg::OFF_W-1:0];
  assign copy_wr_off = copy_rd_off - dpm_pkg::OFF_W'(1);
  assign copy_done   = cnt[dpm_pkg::OFF_W:0] == (dpm_pkg::OFF_W+1)'(dpm_pkg::PAGE_BYTES);
  assign rel_done    = cnt[dpm_pkg::PROC_BYTES_W-1:0] ==
                       dpm_pkg::PROC_BYTES_W'(dpm_pkg::PROC_BYTES - 1);
  assign clr_done    = &cnt;
  assign rel_frame   = cnt[dpm_pkg::PA_W-1:dpm_pkg::OFF_W];

  assign in_ready  = (state == dpm_pkg::S_IDLE);
  assign cfg_ready = !rst;
  assign out_load  = (state == dpm_pkg::S_DONE) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dpm_pkg::S_CLR:  if (clr_done) state_next = dpm_pkg::S_IDLE;
      dpm_pkg::S_IDLE: begin
        if (in_valid) begin
          priority if (in_data.req_type == dpm_pkg::REQ_RELEASE) state_next = dpm_pkg::S_REL;
          else if (in_data.req_type == dpm_pkg::REQ_PRELOAD) state_next = dpm_pkg::S_DONE;
          else if (!in_range) state_next = dpm_pkg::S_DONE;
          else if (in_data.req_type == dpm_pkg::REQ_WRITE) state_next = dpm_pkg::S_WCHK;
          else state_next = dpm_pkg::S_LOOK;
        end
      end
      dpm_pkg::S_REL:  if (rel_done) state_next = dpm_pkg::S_DONE;
      dpm_pkg::S_WCHK: state_next = (bs_rdata != dpm_pkg::SPACE) ? dpm_pkg::S_DONE
                                                                 : dpm_pkg::S_LOOK;
      dpm_pkg::S_LOOK: begin
        priority if (page_valid[cur_pe]) state_next = dpm_pkg::S_ACC;
        else if (any_free) state_next = dpm_pkg::S_LD;
        else state_next = dpm_pkg::S_WB;
      end
      dpm_pkg::S_WB:   if (copy_done) state_next = dpm_pkg::S_LD;
      dpm_pkg::S_LD:   if (copy_done) state_next = dpm_pkg::S_ACC;
      dpm_pkg::S_ACC:  state_next = (cur.req_type == dpm_pkg::REQ_WRITE) ? dpm_pkg::S_DONE
                                                                        : dpm_pkg::S_RD;
      dpm_pkg::S_RD:   state_next = dpm_pkg::S_DONE;
      dpm_pkg::S_DONE: if (out_load) state_next = dpm_pkg::S_IDLE;
      default:         state_next = dpm_pkg::S_IDLE;
    endcase
  end

  // RAM port and LRU control
  always_comb begin
    pr_we    = 1'b0;
    pr_waddr = {frame, copy_wr_off};
    pr_wdata = bs_rdata;
    pr_raddr = {frame, copy_rd_off};
    bs_we    = 1'b0;
    bs_waddr = {victim_pe, copy_wr_off};
    bs_wdata = pr_rdata;
    bs_raddr = {cur_pe, copy_rd_off};
    touch    = '0;
    unique case (state)
      dpm_pkg::S_CLR: begin
        pr_we    = 1'b1;
        pr_waddr = cnt[dpm_pkg::PA_W-1:0];
        pr_wdata = dpm_pkg::SPACE;
        bs_we    = 1'b1;
        bs_waddr = cnt;
        bs_wdata = dpm_pkg::SPACE;
      end
      dpm_pkg::S_IDLE: begin
        bs_raddr = {in_data.proc_id, in_data.vaddr};
        bs_we    = in_valid && (in_data.req_type == dpm_pkg::REQ_PRELOAD);
        bs_waddr = {in_data.proc_id, in_data.vaddr};
        bs_wdata = in_data.wdata;
      end
      dpm_pkg::S_REL: begin
        // the process's backing bytes and the frames it owns go back to spaces
        bs_we    = 1'b1;
        bs_waddr = {cur.proc_id, cnt[dpm_pkg::PROC_BYTES_W-1:0]};
        bs_wdata = dpm_pkg::SPACE;
        pr_we    = !frame_free[rel_frame] && (frame_owner[rel_frame] == cur.proc_id);
        pr_waddr = cnt[dpm_pkg::PA_W-1:0];
        pr_wdata = dpm_pkg::SPACE;
      end
      dpm_pkg::S_LOOK: begin
        touch.en    = page_valid[cur_pe];
        touch.frame = page_frame[cur_pe];
      end
      dpm_pkg::S_WB: begin
        bs_we = (cnt != '0);
      end
      dpm_pkg::S_LD: begin
        pr_we       = (cnt != '0);
        touch.en    = copy_done;
        touch.frame = frame;
      end
      dpm_pkg::S_ACC: begin
        pr_we    = (cur.req_type == dpm_pkg::REQ_WRITE);
        pr_waddr = {frame, cur_off};
        pr_wdata = cur.wdata;
        pr_raddr = {frame, cur_off};
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dpm_pkg::S_CLR;
      cnt        <= '0;
      page_valid <= '0;
      frame_free <= '1;
      out_valid  <= 1'b0;
      for (int i = 0; i < dpm_pkg::PROC_COUNT; i++) page_limit[i] <= '0;
    end else begin
      state <= state_next;

      // configuration writes; indexes past the list are dropped
      if (cfg_valid && (cfg_index < dpm_pkg::CFG_IDX_W'(dpm_pkg::PROC_COUNT))) begin
        page_limit[cfg_index[dpm_pkg::PROC_W-1:0]] <= cfg_data;
      end

      if (out_load) begin
        out_valid <= 1'b1;
        out_data  <= rsp;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        dpm_pkg::S_CLR: cnt <= cnt + CNT_W'(1);
        dpm_pkg::S_IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            cur <= in_data;
            rsp <= '{rdata: '0,
                     status: (in_data.req_type != dpm_pkg::REQ_RELEASE &&
                              in_data.req_type != dpm_pkg::REQ_PRELOAD && !in_range)
                             ? dpm_pkg::ST_RANGE : dpm_pkg::ST_OK,
                     page_fault: 1'b0,
                     evicted: 1'b0,
                     frame_used: '0};
          end
        end
        dpm_pkg::S_REL: begin
          cnt <= cnt + CNT_W'(1);
          if (rel_done) begin
            for (int i = 0; i < dpm_pkg::FRAME_COUNT; i++) begin
              if (frame_owner[i] == cur.proc_id) frame_free[i] <= 1'b1;
            end
            for (int i = 0; i < dpm_pkg::PAGES_PER_PROC; i++) begin
              page_valid[{cur.proc_id, dpm_pkg::VP_W'(i)}] <= 1'b0;
            end
          end
        end
        dpm_pkg::S_WCHK: begin
          if (bs_rdata != dpm_pkg::SPACE) rsp.status <= dpm_pkg::ST_REFUSED;
        end
        dpm_pkg::S_LOOK: begin
          cnt <= '0;
          priority if (page_valid[cur_pe]) frame <= page_frame[cur_pe];
          else if (any_free) begin
            frame <= low_free;
          end else begin
            frame     <= lru_tail;
            victim_pe <= {frame_owner[lru_tail], frame_vpage[lru_tail]};
          end
        end
        dpm_pkg::S_WB: begin
          if (copy_done) begin
            cnt                   <= '0;
            page_valid[victim_pe] <= 1'b0;
            rsp.evicted           <= 1'b1;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        dpm_pkg::S_LD: begin
          cnt <= cnt + CNT_W'(1);
          if (copy_done) begin
            page_valid[cur_pe]  <= 1'b1;
            page_frame[cur_pe]  <= frame;
            frame_free[frame]   <= 1'b0;
            frame_owner[frame]  <= cur.proc_id;
            frame_vpage[frame]  <= cur.vaddr[6:dpm_pkg::OFF_W];
            rsp.page_fault      <= 1'b1;
          end
        end
        dpm_pkg::S_ACC: rsp.frame_used <= frame;
        dpm_pkg::S_RD:  rsp.rdata <= pr_rdata;
        default: ;
      endcase
    end
  end

  dpm_ram #(.WIDTH(8), .DEPTH(dpm_pkg::FRAME_COUNT * dpm_pkg::PAGE_BYTES)) u_phys (
    .clk   (clk),
    .we    (pr_we),
    .waddr (pr_waddr),
    .wdata (pr_wdata),
    .raddr (pr_raddr),
    .rdata (pr_rdata)
  );

  dpm_ram #(.WIDTH(8),
            .DEPTH(dpm_pkg::PROC_COUNT * dpm_pkg::PAGES_PER_PROC * dpm_pkg::PAGE_BYTES)) u_bs (
    .clk   (clk),
    .we    (bs_we),
    .waddr (bs_waddr),
    .wdata (bs_wdata),
    .raddr (bs_raddr),
    .rdata (bs_rdata)
  );

  dpm_lru u_lru (
    .clk   (clk),
    .rst   (rst),
    .touch (touch),
    .tail  (lru_tail)
  );

  // the frame being accessed is resident and owned
  a_acc_resident: assert property (@(posedge clk) disable iff (rst)
    state == dpm_pkg::S_ACC |-> page_valid[cur_pe] && !frame_free[frame])
    else $error("access to a frame that is not resident");

  // eviction only happens with every frame in use
  a_wb_full: assert property (@(posedge clk) disable iff (rst)
    state == dpm_pkg::S_WB |-> frame_free == '0)
    else $error("write-back while a frame is free");

  // a refused write leaves no trace of a fault
  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == dpm_pkg::ST_REFUSED |->
      !out_data.page_fault && !out_data.evicted)
    else $error("refused write reports a fault");

endmodule

// ===== tb/demand_paged_memory_lru_tb.sv =====
// Self-checking testbench for demand_paged_memory_lru: random and directed requests
// are scored against an in-bench model of paging and LRU replacement.
// Depends on dpm_pkg and the block's RTL only.
`timescale 1ns / 100ps

module demand_paged_memory_lru_tb;

  localparam int IDLE_LIMIT = 20000;
  localparam int STALL_LEN  = 600;
  localparam int NPG = dpm_pkg::PROC_COUNT * dpm_pkg::PAGES_PER_PROC;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  dpm_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dpm_pkg::rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dpm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dpm_pkg::LIMIT_W-1:0] cfg_data = '0;

  demand_paged_memory_lru dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model state
  logic [dpm_pkg::LIMIT_W-1:0] lim [dpm_pkg::PROC_COUNT];
  logic [7:0] ram [dpm_pkg::FRAME_COUNT*dpm_pkg::PAGE_BYTES];
  logic [7:0] bstore [NPG*dpm_pkg::PAGE_BYTES];
  bit pg_valid [NPG];
  logic [2:0] pg_frame [NPG];
  bit fr_free [dpm_pkg::FRAME_COUNT];
  logic [1:0] fr_owner [dpm_pkg::FRAME_COUNT];
  logic [2:0] fr_vpage [dpm_pkg::FRAME_COUNT];
  logic [2:0] lru [dpm_pkg::FRAME_COUNT];

  dpm_pkg::req_t pending_reqs [$];
  dpm_pkg::rsp_t expected_rsps [$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;     // no idling on either side
  bit stall_req = 1'b0; // ask the receiver for its long hold-off
  int stall_cnt = 0;    // receiver hold-off cycles spent
  bit in_fire = 1'b0;   // request taken at the last rising edge

  function automatic void model_reset();
    for (int i = 0; i < dpm_pkg::PROC_COUNT; i++) lim[i] = '0;
    for (int i = 0; i < dpm_pkg::FRAME_COUNT*dpm_pkg::PAGE_BYTES; i++) ram[i] = dpm_pkg::SPACE;
    for (int i = 0; i < NPG*dpm_pkg::PAGE_BYTES; i++) bstore[i] = dpm_pkg::SPACE;
    for (int i = 0; i < NPG; i++) begin
      pg_valid[i] = 1'b0;
      pg_frame[i] = '0;
    end
    for (int i = 0; i < dpm_pkg::FRAME_COUNT; i++) begin
      fr_free[i] = 1'b1;
      fr_owner[i] = '0;
      fr_vpage[i] = '0;
      lru[i] = 3'(i);
    end
  endfunction

  // Move frame to the most recent end of the LRU list
  function automatic void lru_touch(logic [2:0] f);
    int pos;
    pos = dpm_pkg::FRAME_COUNT - 1;
    for (int i = 0; i < dpm_pkg::FRAME_COUNT; i++)
      if (lru[i] == f) begin
        pos = i;
        break;
      end
    for (int i = pos; i > 0; i--) lru[i] = lru[i-1];
    lru[0] = f;
  endfunction

  function automatic dpm_pkg::rsp_t predict_access(dpm_pkg::req_t r);
    dpm_pkg::rsp_t o;
    int vp, off, pe, lm, f, ve;
    o = '0;
    vp = r.vaddr / dpm_pkg::PAGE_BYTES;
    off = r.vaddr % dpm_pkg::PAGE_BYTES;
    lm = lim[r.proc_id];
    if (lm > dpm_pkg::PAGES_PER_PROC) lm = dpm_pkg::PAGES_PER_PROC;
    pe = r.proc_id * dpm_pkg::PAGES_PER_PROC + vp;
    case (r.req_type)
      dpm_pkg::REQ_RELEASE: begin
        for (int i = 0; i < dpm_pkg::FRAME_COUNT; i++)
          if (!fr_free[i] && fr_owner[i] == r.proc_id) begin
            for (int b = 0; b < dpm_pkg::PAGE_BYTES; b++)
              ram[i*dpm_pkg::PAGE_BYTES+b] = dpm_pkg::SPACE;
            fr_free[i] = 1'b1;
          end
        for (int i = 0; i < dpm_pkg::PAGES_PER_PROC; i++)
          pg_valid[r.proc_id*dpm_pkg::PAGES_PER_PROC+i] = 1'b0;
        for (int b = 0; b < dpm_pkg::PROC_BYTES; b++)
          bstore[r.proc_id*dpm_pkg::PROC_BYTES+b] = dpm_pkg::SPACE;
      end
      dpm_pkg::REQ_PRELOAD: begin
        if (vp < dpm_pkg::PAGES_PER_PROC) bstore[pe*dpm_pkg::PAGE_BYTES+off] = r.wdata;
        else o.status = dpm_pkg::ST_RANGE;
      end
      default: begin
        if (vp >= lm) o.status = dpm_pkg::ST_RANGE;
        else if (r.req_type == dpm_pkg::REQ_WRITE &&
                 bstore[pe*dpm_pkg::PAGE_BYTES+off] != dpm_pkg::SPACE)
          o.status = dpm_pkg::ST_REFUSED;
        else begin
          if (pg_valid[pe]) begin
            f = pg_frame[pe];
            lru_touch(3'(f));
          end else begin
            f = dpm_pkg::FRAME_COUNT;
            for (int i = 0; i < dpm_pkg::FRAME_COUNT; i++)
              if (fr_free[i]) begin
                f = i;
                break;
              end
            if (f == dpm_pkg::FRAME_COUNT) begin
              // evict the tail frame back to its owner's backing page
              f = lru[dpm_pkg::FRAME_COUNT-1];
              ve = fr_owner[f] * dpm_pkg::PAGES_PER_PROC + fr_vpage[f];
              for (int b = 0; b < dpm_pkg::PAGE_BYTES; b++)
                bstore[ve*dpm_pkg::PAGE_BYTES+b] = ram[f*dpm_pkg::PAGE_BYTES+b];
              pg_valid[ve] = 1'b0;
              o.evicted = 1'b1;
            end
            for (int b = 0; b < dpm_pkg::PAGE_BYTES; b++)
              ram[f*dpm_pkg::PAGE_BYTES+b] = bstore[pe*dpm_pkg::PAGE_BYTES+b];
            pg_valid[pe] = 1'b1;
            pg_frame[pe] = 3'(f);
            lru_touch(3'(f));
            fr_free[f] = 1'b0;
            fr_owner[f] = r.proc_id;
            fr_vpage[f] = 3'(vp);
            o.page_fault = 1'b1;
          end
          if (r.req_type == dpm_pkg::REQ_WRITE) ram[f*dpm_pkg::PAGE_BYTES+off] = r.wdata;
          else o.rdata = ram[f*dpm_pkg::PAGE_BYTES+off];
          o.frame_used = 3'(f);
        end
      end
    endcase
    return o;
  endfunction

  // Driver: holds a waiting request, otherwise presents the next queued one
  always @(negedge clk) begin
    if (!rst) begin
      if (!(in_valid && !in_fire)) begin
        if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 10)) begin
          in_valid <= 1'b1;
          in_data <= pending_reqs[0];
        end else
          in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random idling, plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_req && stall_cnt < STALL_LEN) begin
        stall_cnt <= stall_cnt + 1;
        out_ready <= 1'b0;
      end else
        out_ready <= quiet || $urandom_range(99) >= 10;
    end
  end

  // Monitor, predictor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding");
          errors++;
        end else begin
          dpm_pkg::rsp_t e;
          e = expected_rsps.pop_front();
          if (e.rdata != out_data.rdata) begin
            $error("rdata exp %0h got %0h", e.rdata, out_data.rdata); errors++;
          end
          if (e.status != out_data.status) begin
            $error("status exp %0d got %0d", e.status, out_data.status); errors++;
          end
          if (e.page_fault != out_data.page_fault) begin
            $error("page_fault exp %0d got %0d", e.page_fault, out_data.page_fault);
            errors++;
          end
          if (e.evicted != out_data.evicted) begin
            $error("evicted exp %0d got %0d", e.evicted, out_data.evicted); errors++;
          end
          if (e.frame_used != out_data.frame_used) begin
            $error("frame_used exp %0d got %0d", e.frame_used, out_data.frame_used);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_rsps = {expected_rsps, predict_access(in_data)};
        void'(pending_reqs.pop_front());
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("demand_paged_memory_lru: mismatch");
        $finish;
      end
    end
  end

  task automatic write_limit(input int idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= dpm_pkg::CFG_IDX_W'(idx);
    cfg_data <= dpm_pkg::LIMIT_W'(val);
    do @(posedge clk); while (!cfg_ready);
    if (idx < dpm_pkg::PROC_COUNT) lim[idx] = dpm_pkg::LIMIT_W'(val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic queue_req(input dpm_pkg::req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic dpm_pkg::req_t make_req(logic [1:0] t, logic [1:0] p, logic [6:0] va,
                                             logic [7:0] wd);
    dpm_pkg::req_t r;
    r.req_type = t;
    r.proc_id = p;
    r.vaddr = va;
    r.wdata = wd;
    return r;
  endfunction

  // Mostly reads, writes and preloads over all pages; occasional releases
  function automatic dpm_pkg::req_t rand_req();
    int k;
    logic [7:0] wd;
    k = $urandom_range(99);
    wd = ($urandom_range(3) == 0) ? dpm_pkg::SPACE : 8'($urandom);
    if (k < 40)
      return make_req(dpm_pkg::REQ_READ, 2'($urandom), 7'($urandom_range(127)), wd);
    if (k < 75)
      return make_req(dpm_pkg::REQ_WRITE, 2'($urandom), 7'($urandom_range(127)), wd);
    if (k < 97)
      return make_req(dpm_pkg::REQ_PRELOAD, 2'($urandom), 7'($urandom_range(127)), wd);
    return make_req(dpm_pkg::REQ_RELEASE, 2'($urandom), 7'($urandom), 8'($urandom));
  endfunction

  initial begin
    model_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: range errors at limit 0, then extremes and replacement
    queue_req(make_req(dpm_pkg::REQ_READ, 2'd0, 7'd0, 8'd0));
    queue_req(make_req(dpm_pkg::REQ_WRITE, 2'd3, 7'd127, 8'hFF));
    queue_req(make_req(dpm_pkg::REQ_PRELOAD, 2'd3, 7'd127, 8'hFF));
    queue_req(make_req(dpm_pkg::REQ_PRELOAD, 2'd0, 7'd5, 8'h41));
    queue_req(make_req(dpm_pkg::REQ_RELEASE, 2'd2, 7'd0, 8'd0));
    wait_drained();
    write_limit(0, 8);
    write_limit(1, 15);
    write_limit(2, 1);
    write_limit(3, 0);
    write_limit(5, 3);   // index beyond the registers: ignored
    // write refused: backing byte not a space
    queue_req(make_req(dpm_pkg::REQ_WRITE, 2'd0, 7'd5, 8'h55));
    queue_req(make_req(dpm_pkg::REQ_READ, 2'd0, 7'd5, 8'd0));
    queue_req(make_req(dpm_pkg::REQ_WRITE, 2'd0, 7'd6, 8'h00));
    // fill all frames and go past to force eviction
    for (int i = 0; i < 8; i++)
      queue_req(make_req(dpm_pkg::REQ_WRITE, 2'd1, 7'(i*16+15), 8'(i)));
    queue_req(make_req(dpm_pkg::REQ_READ, 2'd0, 7'd127, 8'd0));
    queue_req(make_req(dpm_pkg::REQ_READ, 2'd0, 7'd6, 8'd0));
    queue_req(make_req(dpm_pkg::REQ_READ, 2'd2, 7'd16, 8'd0));
    queue_req(make_req(dpm_pkg::REQ_READ, 2'd3, 7'd0, 8'd0));
    queue_req(make_req(dpm_pkg::REQ_RELEASE, 2'd1, 7'd0, 8'd0));
    queue_req(make_req(dpm_pkg::REQ_READ, 2'd1, 7'd15, 8'd0));
    wait_drained();

    // Random phases under changing limits; the third phase has no idling
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 4; i++)
        write_limit(i, (ph == 5) ? 0 : (ph == 0 ? 8 : $urandom_range(15)));
      quiet = (ph == 2);
      if (ph == 3) stall_req = 1'b1;
      for (int n = 0; n < 190; n++) queue_req(rand_req());
      wait_drained();
    end
    quiet = 1'b0;

    if (expected_rsps.size() != 0) begin
      $error("%0d responses never arrived", expected_rsps.size());
      errors++;
    end
    if (errors == 0)
      $display("demand_paged_memory_lru: match");
    else
      $display("demand_paged_memory_lru: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dpm_pkg.sv
rtl/dpm_ram.sv
rtl/dpm_lru.sv
rtl/demand_paged_memory_lru.sv
tb/demand_paged_memory_lru_tb.sv
